// ===== sv/i2c_rts_pkg.sv =====
// Shared types and constants for the I2C register transaction sequencer.
// Used by the top level i2c_register_transaction_sequencer; no dependencies.
package i2c_rts_pkg;

    // Request codes carried in the input tuser.
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_PROBE  = 3'd2;
    localparam logic [2:0] REQ_ENGINE = 3'd3;
    localparam logic [2:0] REQ_STOP   = 3'd4;

    // Result kinds carried in the output tuser.
    localparam logic [1:0] KIND_OP   = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Engine operations.
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_SEND    = 3'd1;
    localparam logic [2:0] OP_RACK    = 3'd2;
    localparam logic [2:0] OP_RNACK   = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_ABANDON = 3'd5;
    localparam logic [2:0] OP_RELEASE = 3'd6;
    localparam logic [2:0] OP_RESET   = 3'd7;

    // Failure stages.
    localparam logic [2:0] STAGE_START = 3'd1;
    localparam logic [2:0] STAGE_ADDR  = 3'd2;
    localparam logic [2:0] STAGE_WDATA = 3'd3;
    localparam logic [2:0] STAGE_RDATA = 3'd4;

    // Engine status codes (after masking).
    localparam logic [7:0] ST_MASK      = 8'hF8;
    localparam logic [7:0] ST_TIMEOUT   = 8'hFF;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;

    // Result queue sizing: one input word can cause up to three results.
    localparam int MAX_RES     = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int READY_LIMIT = FIFO_DEPTH - 2 * MAX_RES;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_START  = 9'b000000010,
        PH_ADDR   = 9'b000000100,
        PH_REG    = 9'b000001000,
        PH_VAL    = 9'b000010000,
        PH_RSTART = 9'b000100000,
        PH_RADDR  = 9'b001000000,
        PH_READ   = 9'b010000000,
        PH_STOPW  = 9'b100000000
    } phase_t;

    // Input tdata layout, lowest field in the lowest bits.
    typedef struct packed {
        logic [4:0] pad;
        logic [1:0] line_levels;
        logic       stop_stuck;
        logic [7:0] engine_data;
        logic       engine_timeout;
        logic [7:0] engine_status;
        logic [7:0] read_count;
        logic [7:0] wr_value;
        logic [7:0] reg_addr;
        logic [6:0] dev_addr;
    } in_word_t;

    // Output tdata layout, lowest field in the lowest bits.
    typedef struct packed {
        logic        pad;
        logic [15:0] stuck_count;
        logic [7:0]  fail_status;
        logic [2:0]  fail_stage;
        logic        done_ok;
        logic [7:0]  read_byte;
        logic [7:0]  engine_byte;
        logic [2:0]  engine_op;
    } out_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        out_word_t  data;
    } res_t;

    function automatic res_t make_res(input logic [1:0] kind, input logic [2:0] op,
                                      input logic [7:0] byte_val, input logic [7:0] rbyte,
                                      input logic ok, input logic [2:0] stage,
                                      input logic [7:0] status, input logic [15:0] count);
        res_t r;
        r                  = '0;
        r.kind             = kind;
        r.data.engine_op   = op;
        r.data.engine_byte = byte_val;
        r.data.read_byte   = rbyte;
        r.data.done_ok     = ok;
        r.data.fail_stage  = stage;
        r.data.fail_status = status;
        r.data.stuck_count = count;
        return r;
    endfunction

endpackage

// ===== sv/i2c_register_transaction_sequencer.sv =====
// Top level of the I2C register transaction sequencer: decision logic and result queue.
// Depends on i2c_rts_pkg for codes, the phase type and the word layouts.
//
// Usage: commands (register write, burst read, probe) and events from the byte-level
// I2C engine (operation completion, stop result) arrive as words on the slave stream.
// s_tuser selects the request, s_tdata carries its fields. Each word causes zero to
// three result words on the master stream: engine operations to issue, received data
// bytes, and a transaction-done report; m_tuser gives the kind and m_tlast marks the
// final result of one input word.
// Data path: an accepted word is held in an input register and evaluated there; its
// results are then written into an eight-entry result queue, whose head is presented
// on the master side.
// Throughput: one input word per cycle as long as the queue holds no more than two
// results; the output side drains one result per cycle while m_tready is high.
// Reset clears the queue, the input valid flag and all sequencer state; the phase
// returns to idle, the transaction-ok flag is set and the recovery counter is zero.
// When the receiver stalls, results wait in the queue and s_tready drops once the
// queue cannot take two more words' worth of results.
module i2c_register_transaction_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: dev_addr[6:0], reg_addr[7:0], wr_value[7:0], read_count[7:0],
    // engine_status[7:0], engine_timeout, engine_data[7:0], stop_stuck, line_levels[1:0],
    // five zero bits
    input  logic [55:0] s_tdata,
    // s_tuser: req_type[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: engine_op[2:0], engine_byte[7:0], read_byte[7:0], done_ok,
    // fail_stage[2:0], fail_status[7:0], stuck_count[15:0], one zero bit
    output logic [47:0] m_tdata,
    // m_tuser: out_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    // Input register.
    logic                  in_valid_reg;
    i2c_rts_pkg::in_word_t in_data_reg;
    logic [2:0]            in_req_reg;

    // Sequencer state.
    i2c_rts_pkg::phase_t phase_reg, phase_next;
    logic [1:0]          kind_reg, kind_next;
    logic [6:0]          dev_reg, dev_next;
    logic [7:0]          regad_reg, regad_next;
    logic [7:0]          value_reg, value_next;
    logic [7:0]          left_reg, left_next;
    logic [7:0]          lstat_reg, lstat_next;
    logic [2:0]          sstage_reg, sstage_next;
    logic [7:0]          sstat_reg, sstat_next;
    logic                ok_reg, ok_next;
    logic [15:0]         rec_reg, rec_next;

    // Result queue.
    i2c_rts_pkg::res_t            fifo_reg [i2c_rts_pkg::FIFO_DEPTH];
    logic [i2c_rts_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [i2c_rts_pkg::CNT_W-1:0] count_reg;

    i2c_rts_pkg::res_t res [i2c_rts_pkg::MAX_RES];
    logic [1:0]        nres;
    logic              pop;

    // Decision flags that route into the shared stop and done tails.
    logic       do_fail, do_stop, do_done;
    logic [2:0] f_stage;
    logic [7:0] f_status;
    logic [7:0] st;
    logic [7:0] addr_w, addr_r;
    logic       tmo;

    assign s_tready = (count_reg <= i2c_rts_pkg::CNT_W'(i2c_rts_pkg::READY_LIMIT));
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = fifo_reg[rd_ptr_reg].data;
    assign m_tuser  = fifo_reg[rd_ptr_reg].kind;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

    assign st     = in_data_reg.engine_status & i2c_rts_pkg::ST_MASK;
    assign tmo    = in_data_reg.engine_timeout;
    assign addr_w = {dev_reg, 1'b0};
    assign addr_r = {dev_reg, 1'b1};

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        dev_next    = dev_reg;
        regad_next  = regad_reg;
        value_next  = value_reg;
        left_next   = left_reg;
        lstat_next  = lstat_reg;
        sstage_next = sstage_reg;
        sstat_next  = sstat_reg;
        ok_next     = ok_reg;
        rec_next    = rec_reg;
        do_fail     = 1'b0;
        do_stop     = 1'b0;
        do_done     = 1'b0;
        f_stage     = '0;
        f_status    = '0;
        nres        = '0;
        for (int i = 0; i < i2c_rts_pkg::MAX_RES; i++)
        begin
            res[i] = '0;
        end

        if (in_valid_reg)
        begin
            case (in_req_reg)
                i2c_rts_pkg::REQ_WRITE, i2c_rts_pkg::REQ_READ, i2c_rts_pkg::REQ_PROBE:
                begin
                    if (phase_reg == i2c_rts_pkg::PH_IDLE)
                    begin
                        kind_next  = in_req_reg[1:0];
                        dev_next   = in_data_reg.dev_addr;
                        regad_next = in_data_reg.reg_addr;
                        value_next = in_data_reg.wr_value;
                        left_next  = in_data_reg.read_count;
                        ok_next    = 1'b1;
                        if (in_req_reg == i2c_rts_pkg::REQ_READ && in_data_reg.read_count == '0)
                        begin
                            do_done = 1'b1;
                        end
                        else
                        begin
                            res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                         i2c_rts_pkg::OP_START, '0, '0, 1'b0, '0, '0, rec_reg);
                            nres = 2'd1;
                            phase_next = i2c_rts_pkg::PH_START;
                        end
                    end
                end
                i2c_rts_pkg::REQ_ENGINE:
                begin
                    if (phase_reg != i2c_rts_pkg::PH_IDLE && phase_reg != i2c_rts_pkg::PH_STOPW)
                    begin
                        lstat_next = st;
                    end
                    case (phase_reg)
                        i2c_rts_pkg::PH_START, i2c_rts_pkg::PH_RSTART:
                        begin
                            f_stage = i2c_rts_pkg::STAGE_START;
                            if (tmo || (st != i2c_rts_pkg::ST_START
                                        && st != i2c_rts_pkg::ST_RSTART))
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                             i2c_rts_pkg::OP_SEND,
                                             (phase_reg == i2c_rts_pkg::PH_START) ? addr_w
                                                                                  : addr_r,
                                             '0, 1'b0, '0, '0, rec_reg);
                                nres = 2'd1;
                                phase_next = (phase_reg == i2c_rts_pkg::PH_START)
                                             ? i2c_rts_pkg::PH_ADDR : i2c_rts_pkg::PH_RADDR;
                            end
                        end
                        i2c_rts_pkg::PH_ADDR:
                        begin
                            f_stage = i2c_rts_pkg::STAGE_ADDR;
                            if (tmo || (st != i2c_rts_pkg::ST_SLAW_ACK
                                        && st != i2c_rts_pkg::ST_SLAR_ACK))
                            begin
                                do_fail = 1'b1;
                            end
                            else if (kind_reg == i2c_rts_pkg::REQ_PROBE[1:0])
                            begin
                                do_stop = 1'b1;
                            end
                            else
                            begin
                                res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                             i2c_rts_pkg::OP_SEND, regad_reg, '0, 1'b0,
                                             '0, '0, rec_reg);
                                nres = 2'd1;
                                phase_next = i2c_rts_pkg::PH_REG;
                            end
                        end
                        i2c_rts_pkg::PH_REG:
                        begin
                            f_stage = i2c_rts_pkg::STAGE_WDATA;
                            if (tmo || st != i2c_rts_pkg::ST_DATA_ACK)
                            begin
                                do_fail = 1'b1;
                            end
                            else if (kind_reg == i2c_rts_pkg::REQ_WRITE[1:0])
                            begin
                                res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                             i2c_rts_pkg::OP_SEND, value_reg, '0, 1'b0,
                                             '0, '0, rec_reg);
                                nres = 2'd1;
                                phase_next = i2c_rts_pkg::PH_VAL;
                            end
                            else
                            begin
                                res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                             i2c_rts_pkg::OP_START, '0, '0, 1'b0,
                                             '0, '0, rec_reg);
                                nres = 2'd1;
                                phase_next = i2c_rts_pkg::PH_RSTART;
                            end
                        end
                        i2c_rts_pkg::PH_VAL:
                        begin
                            f_stage = i2c_rts_pkg::STAGE_WDATA;
                            if (tmo || st != i2c_rts_pkg::ST_DATA_ACK)
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                do_stop = 1'b1;
                            end
                        end
                        i2c_rts_pkg::PH_RADDR:
                        begin
                            f_stage = i2c_rts_pkg::STAGE_ADDR;
                            if (tmo || (st != i2c_rts_pkg::ST_SLAW_ACK
                                        && st != i2c_rts_pkg::ST_SLAR_ACK))
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                             (left_reg > 8'd1) ? i2c_rts_pkg::OP_RACK
                                                               : i2c_rts_pkg::OP_RNACK,
                                             '0, '0, 1'b0, '0, '0, rec_reg);
                                nres = 2'd1;
                                phase_next = i2c_rts_pkg::PH_READ;
                            end
                        end
                        i2c_rts_pkg::PH_READ:
                        begin
                            f_stage = i2c_rts_pkg::STAGE_RDATA;
                            if (tmo || st != ((left_reg > 8'd1) ? i2c_rts_pkg::ST_RX_ACK
                                                                : i2c_rts_pkg::ST_RX_NACK))
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_BYTE,
                                             3'd0, '0, in_data_reg.engine_data, 1'b0,
                                             '0, '0, rec_reg);
                                nres = 2'd1;
                                if (left_reg != '0)
                                begin
                                    left_next = left_reg - 8'd1;
                                end
                                if (left_next != '0)
                                begin
                                    res[1] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                                 (left_next > 8'd1) ? i2c_rts_pkg::OP_RACK
                                                                    : i2c_rts_pkg::OP_RNACK,
                                                 '0, '0, 1'b0, '0, '0, rec_reg);
                                    nres = 2'd2;
                                end
                                else
                                begin
                                    do_stop = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    f_status = tmo ? i2c_rts_pkg::ST_TIMEOUT : st;
                end
                i2c_rts_pkg::REQ_STOP:
                begin
                    if (phase_reg == i2c_rts_pkg::PH_STOPW)
                    begin
                        if (in_data_reg.stop_stuck)
                        begin
                            rec_next = rec_reg + 16'd1;
                            // A line held low gets released; otherwise the engine is reset.
                            res[0] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                         (in_data_reg.line_levels != 2'b11)
                                         ? i2c_rts_pkg::OP_RELEASE : i2c_rts_pkg::OP_RESET,
                                         '0, '0, 1'b0, '0, '0, rec_next);
                            nres = 2'd1;
                        end
                        do_done = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (do_fail)
            begin
                sstage_next = f_stage;
                sstat_next  = f_status;
                ok_next     = 1'b0;
                do_stop     = 1'b1;
            end

            // The STOP path: after an address or write-data NACK status the engine is abandoned, else STOP is sent.
            if (do_stop)
            begin
                if (lstat_next == i2c_rts_pkg::ST_SLAW_NACK
                    || lstat_next == i2c_rts_pkg::ST_SLAR_NACK
                    || lstat_next == i2c_rts_pkg::ST_DATA_NACK)
                begin
                    res[nres] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                    i2c_rts_pkg::OP_ABANDON, '0, '0, 1'b0, '0, '0, rec_next);
                    nres    = nres + 2'd1;
                    do_done = 1'b1;
                end
                else
                begin
                    res[nres] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_OP,
                                    i2c_rts_pkg::OP_STOP, '0, '0, 1'b0, '0, '0, rec_next);
                    nres       = nres + 2'd1;
                    phase_next = i2c_rts_pkg::PH_STOPW;
                end
            end

            if (do_done)
            begin
                res[nres] = i2c_rts_pkg::make_res(i2c_rts_pkg::KIND_DONE, 3'd0, '0, '0,
                                ok_next, ok_next ? 3'd0 : sstage_next,
                                ok_next ? 8'd0 : sstat_next, rec_next);
                nres       = nres + 2'd1;
                phase_next = i2c_rts_pkg::PH_IDLE;
            end

            if (nres != '0)
            begin
                res[nres - 2'd1].last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= i2c_rts_pkg::PH_IDLE;
            kind_reg     <= '0;
            dev_reg      <= '0;
            regad_reg    <= '0;
            value_reg    <= '0;
            left_reg     <= '0;
            lstat_reg    <= '0;
            sstage_reg   <= '0;
            sstat_reg    <= '0;
            ok_reg       <= 1'b1;
            rec_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= s_tvalid && s_tready;
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            dev_reg      <= dev_next;
            regad_reg    <= regad_next;
            value_reg    <= value_next;
            left_reg     <= left_next;
            lstat_reg    <= lstat_next;
            sstage_reg   <= sstage_next;
            sstat_reg    <= sstat_next;
            ok_reg       <= ok_next;
            rec_reg      <= rec_next;
            wr_ptr_reg   <= wr_ptr_reg + i2c_rts_pkg::PTR_W'(nres);
            rd_ptr_reg   <= rd_ptr_reg + i2c_rts_pkg::PTR_W'(pop);
            count_reg    <= count_reg + i2c_rts_pkg::CNT_W'(nres)
                            - i2c_rts_pkg::CNT_W'(pop);
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_req_reg  <= s_tuser;
        end
        for (int i = 0; i < i2c_rts_pkg::MAX_RES; i++)
        begin
            if (2'(i) < nres)
            begin
                fifo_reg[wr_ptr_reg + i2c_rts_pkg::PTR_W'(i)] <= res[i];
            end
        end
    end

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= i2c_rts_pkg::CNT_W'(i2c_rts_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A word under evaluation always finds room for its worst-case results.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> ({1'b0, count_reg} + 5'(i2c_rts_pkg::MAX_RES)
                          <= 5'(i2c_rts_pkg::FIFO_DEPTH)))
        else $error("no room for results of the word under evaluation");

    // The recovery counter moves only on a stop result evaluated in the prior cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_reg != $past(rec_reg)) |->
            $past(in_valid_reg && in_req_reg == i2c_rts_pkg::REQ_STOP))
        else $error("recovery counter changed without a stop result");

    // A stuck-stop recovery always advances the counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_req_reg == i2c_rts_pkg::REQ_STOP
         && phase_reg == i2c_rts_pkg::PH_STOPW && in_data_reg.stop_stuck)
        |=> (rec_reg == $past(rec_reg) + 16'd1))
        else $error("recovery counter did not advance");

endmodule
